/* hdl/fia_pkg.sv */
// ----------------------------------------------------------------------------
// fia_pkg
// Shared types, codes and helpers of the formatted integer to ASCII unit.
// ----------------------------------------------------------------------------
package fia_pkg;

   localparam int NUM_W       = 64;
   localparam int BCD_DIGITS  = 20;
   localparam int BCD_W       = 4 * BCD_DIGITS;
   localparam int BUF_DEPTH   = 64;
   localparam int BUF_AW      = 6;
   localparam int CHAR_W      = 8;

   // conversion selectors
   localparam logic [2:0] FUNC_BIN  = 3'd0;
   localparam logic [2:0] FUNC_SDEC = 3'd1;
   localparam logic [2:0] FUNC_OCT  = 3'd2;
   localparam logic [2:0] FUNC_UDEC = 3'd3;
   localparam logic [2:0] FUNC_HEXL = 3'd4;
   localparam logic [2:0] FUNC_HEXU = 3'd5;
   localparam logic [2:0] FUNC_CHAR = 3'd6;
   localparam logic [2:0] FUNC_LIT  = 3'd7;

   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_LOWER_A = 8'h61;

   typedef struct packed {
      logic [2:0]  func;
      logic [63:0] arg_value;
      logic        long_form;
      logic [6:0]  field_width;
      logic        left_adjust;
      logic        zero_pad;
   } fia_req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       last;
   } fia_rsp_type;

   // order of the sign, pad and body segments in the field
   typedef enum logic [1:0] {
      ORD_LEFT,
      ORD_ZERO,
      ORD_SPACE
   } ord_type;

   typedef enum logic [1:0] {
      SEG_SIGN,
      SEG_PAD,
      SEG_BODY
   } seg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUTE,
      ST_CONV,
      ST_DIGIT,
      ST_PLAN,
      ST_EMIT,
      ST_FETCH,
      ST_BODY
   } state_type;

   typedef struct packed {
      logic load;
      logic conv_step;
      logic digit_step;
      logic plan;
      logic emit_sign;
      logic emit_pad;
      logic fetch;
      logic emit_body;
      logic last;
   } fia_cmd_type;

   typedef struct packed {
      logic    is_dec;
      logic    is_num;
      logic    conv_last;
      logic    digit_last;
      logic    neg;
      logic    pad_zero;
      logic    pad_one;
      logic    body_one;
      ord_type ord;
      logic    slot_free;
   } fia_stat_type;

   function automatic seg_type seg_of(ord_type ord, logic [1:0] pos);
      seg_type seg;
      seg = SEG_BODY;
      unique case (ord)
         ORD_LEFT: begin
            case (pos)
               2'd0:    seg = SEG_SIGN;
               2'd1:    seg = SEG_BODY;
               default: seg = SEG_PAD;
            endcase
         end
         ORD_ZERO: begin
            case (pos)
               2'd0:    seg = SEG_SIGN;
               2'd1:    seg = SEG_PAD;
               default: seg = SEG_BODY;
            endcase
         end
         default: begin
            case (pos)
               2'd0:    seg = SEG_PAD;
               2'd1:    seg = SEG_SIGN;
               default: seg = SEG_BODY;
            endcase
         end
      endcase
      return seg;
   endfunction

   function automatic logic [7:0] digit_char(logic [3:0] d, logic upper);
      logic [7:0] ch;
      if (d <= 4'd9) begin
         ch = CH_ZERO + {4'b0, d};
      end else if (upper) begin
         ch = CH_UPPER_A + {4'b0, d} - 8'd10;
      end else begin
         ch = CH_LOWER_A + {4'b0, d} - 8'd10;
      end
      return ch;
   endfunction

endpackage

/* hdl/formatted_integer_to_ascii_unit.sv */
// ----------------------------------------------------------------------------
// formatted_integer_to_ascii_unit
// Formats one parsed printf-style conversion into a stream of ASCII chars.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_payload carry one conversion: selector, 64-bit
//   argument, long flag, field width, left-adjust and zero-pad flags.
//   rsp_valid/rsp_ready/rsp_payload return the characters of the field one
//   per transaction, with last set on the final one.
//   One conversion is worked on at a time. Decimal conversions first run a
//   shift-add-3 binary to BCD pass over all 64 argument bits; then one digit
//   per cycle goes into the 64-entry digit buffer (up to 20 decimal, 22
//   octal, 16 hex or 64 binary digits). Output then emits the sign, pad and
//   body characters in field order; each body character is first read from
//   the buffer, then loaded into the result register, and empty segments
//   are skipped. Character and literal conversions skip the digit steps.
//   The next transaction is accepted as soon as the final character is in
//   the result register, while that character still waits to be taken.
//   A stall on rsp_ready holds the result register and pauses the
//   character sequencer. Reset clears the controller and the result valid;
//   the digit buffer needs no clearing since every digit is written first.
// ----------------------------------------------------------------------------
module formatted_integer_to_ascii_unit #(
   parameter int MAX_FIELD = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fia_pkg::fia_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fia_pkg::fia_rsp_type rsp_payload
);

   fia_pkg::fia_cmd_type  cmd;
   fia_pkg::fia_stat_type stat;

   fia_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fia_dpath #(
      .MAX_FIELD (MAX_FIELD)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

/* hdl/fia_ram.sv */
// ----------------------------------------------------------------------------
// fia_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fia_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fia_dpath.sv */
// ----------------------------------------------------------------------------
// fia_dpath
// Datapath: argument capture, binary to BCD converter, digit extraction into
// the digit buffer, pad and body counters, and the result register.
// ----------------------------------------------------------------------------
module fia_dpath #(
   parameter int MAX_FIELD = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  fia_pkg::fia_req_type req_payload,
   input  fia_pkg::fia_cmd_type cmd,
   output fia_pkg::fia_stat_type stat,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fia_pkg::fia_rsp_type rsp_payload
);

   localparam logic [7:0] MAX_W = 8'(MAX_FIELD);

   logic [2:0]                   func_ff;
   logic                         neg_ff;
   logic [7:0]                   ch_ff;
   logic [6:0]                   width_ff;
   logic                         ladj_ff;
   logic                         zpad_ff;
   logic [63:0]                  src_ff;
   logic [fia_pkg::BCD_W-1:0]    work_ff;
   logic [6:0]                   dcnt_ff;
   logic [5:0]                   cnt_ff;
   logic [6:0]                   pad_ff;
   logic [6:0]                   idx_ff;
   logic                         rsp_valid_ff;
   fia_pkg::fia_rsp_type         rsp_data_ff;

   logic [63:0]                  v_ext;
   logic                         neg_in;
   logic [63:0]                  mag;
   logic                         load_dec;
   logic                         load_num;
   logic [6:0]                   width_sat;
   logic [fia_pkg::BCD_W-1:0]    bcd_adj;
   logic [fia_pkg::BCD_W-1:0]    work_shift;
   logic [3:0]                   digit_mask;
   logic [7:0]                   digit_ch;
   logic [6:0]                   actual;
   logic [7:0]                   ram_rd_data;
   logic [7:0]                   pad_ch;
   logic [7:0]                   out_ch;
   logic                         is_num;
   logic                         emit_any;

   // argument preparation at load
   always_comb begin
      v_ext    = req_payload.long_form ? req_payload.arg_value
                 : {{32{req_payload.arg_value[31]}}, req_payload.arg_value[31:0]};
      neg_in   = (req_payload.func == fia_pkg::FUNC_SDEC) && v_ext[63];
      mag      = neg_in ? (64'd0 - v_ext) : v_ext;
      load_dec = (req_payload.func == fia_pkg::FUNC_SDEC) ||
                 (req_payload.func == fia_pkg::FUNC_UDEC);
      load_num = (req_payload.func != fia_pkg::FUNC_CHAR) &&
                 (req_payload.func != fia_pkg::FUNC_LIT);
      width_sat = ({1'b0, req_payload.field_width} > MAX_W) ? MAX_W[6:0]
                  : req_payload.field_width;
   end

   // one shift-add-3 step of the binary to BCD conversion
   always_comb begin
      logic [3:0] nib;
      nib = '0;
      for (int i = 0; i < fia_pkg::BCD_DIGITS; i++) begin
         nib = work_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
      end
   end

   // per-base digit mask and shift
   always_comb begin
      unique case (func_ff)
         fia_pkg::FUNC_BIN: begin
            digit_mask = 4'h1;
            work_shift = work_ff >> 1;
         end
         fia_pkg::FUNC_OCT: begin
            digit_mask = 4'h7;
            work_shift = work_ff >> 3;
         end
         default: begin
            digit_mask = 4'hF;
            work_shift = work_ff >> 4;
         end
      endcase
      digit_ch = fia_pkg::digit_char(work_ff[3:0] & digit_mask,
                                     func_ff == fia_pkg::FUNC_HEXU);
   end

   assign actual = dcnt_ff + {6'b0, neg_ff};
   assign is_num = (func_ff != fia_pkg::FUNC_CHAR) && (func_ff != fia_pkg::FUNC_LIT);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_payload.func;
         neg_ff   <= neg_in;
         ch_ff    <= req_payload.arg_value[7:0];
         width_ff <= (req_payload.func == fia_pkg::FUNC_LIT) ? 7'd0 : width_sat;
         ladj_ff  <= req_payload.left_adjust;
         zpad_ff  <= req_payload.zero_pad;
         src_ff   <= mag;
         work_ff  <= load_dec ? '0 : {16'b0, mag};
         dcnt_ff  <= load_num ? 7'd0 : 7'd1;
         cnt_ff   <= 6'd63;
      end
      if (cmd.conv_step) begin
         work_ff <= {bcd_adj[fia_pkg::BCD_W-2:0], src_ff[63]};
         src_ff  <= {src_ff[62:0], 1'b0};
         cnt_ff  <= cnt_ff - 6'd1;
      end
      if (cmd.digit_step) begin
         work_ff <= work_shift;
         dcnt_ff <= dcnt_ff + 7'd1;
      end
      if (cmd.plan) begin
         pad_ff <= (width_ff > actual) ? width_ff - actual : 7'd0;
         idx_ff <= dcnt_ff;
      end
      if (cmd.emit_pad) begin
         pad_ff <= pad_ff - 7'd1;
      end
      if (cmd.emit_body) begin
         idx_ff <= idx_ff - 7'd1;
      end
   end

   fia_ram #(
      .WIDTH (fia_pkg::CHAR_W),
      .DEPTH (fia_pkg::BUF_DEPTH)
   ) u_digit_buf (
      .clock   (clock),
      .wr_en   (cmd.digit_step),
      .wr_addr (dcnt_ff[fia_pkg::BUF_AW-1:0]),
      .wr_data (digit_ch),
      .rd_en   (cmd.fetch),
      .rd_addr (idx_ff[fia_pkg::BUF_AW-1:0] - 6'd1),
      .rd_data (ram_rd_data)
   );

   // result register
   always_comb begin
      pad_ch   = (stat.ord == fia_pkg::ORD_ZERO) ? fia_pkg::CH_ZERO : fia_pkg::CH_SPACE;
      emit_any = cmd.emit_sign || cmd.emit_pad || cmd.emit_body;
      priority if (cmd.emit_sign) begin
         out_ch = fia_pkg::CH_MINUS;
      end else if (cmd.emit_pad) begin
         out_ch = pad_ch;
      end else begin
         out_ch = is_num ? ram_rd_data : ch_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_any) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_any) begin
         rsp_data_ff.out_char <= out_ch;
         rsp_data_ff.last     <= cmd.last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      stat.is_dec     = (func_ff == fia_pkg::FUNC_SDEC) || (func_ff == fia_pkg::FUNC_UDEC);
      stat.is_num     = is_num;
      stat.conv_last  = (cnt_ff == 6'd0);
      stat.digit_last = (work_shift == '0) || (dcnt_ff == 7'd63);
      stat.neg        = neg_ff;
      stat.pad_zero   = (pad_ff == 7'd0);
      stat.pad_one    = (pad_ff == 7'd1);
      stat.body_one   = (idx_ff == 7'd1);
      if (ladj_ff) begin
         stat.ord = fia_pkg::ORD_LEFT;
      end else if (is_num && zpad_ff) begin
         stat.ord = fia_pkg::ORD_ZERO;
      end else begin
         stat.ord = fia_pkg::ORD_SPACE;
      end
      stat.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   a_digit_room: assert property (@(posedge clock) disable iff (reset)
      cmd.digit_step |-> dcnt_ff < 7'd64)
      else $error("digit buffer overrun");

   a_pad_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_pad |-> pad_ff != 7'd0)
      else $error("pad emitted with empty pad count");

   a_body_nonzero: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_body |-> idx_ff != 7'd0)
      else $error("body emitted with no characters left");

endmodule

/* hdl/fia_ctrl.sv */
// ----------------------------------------------------------------------------
// fia_ctrl
// Controller: sequences load, conversion, digit extraction and the sign, pad
// and body segments of the formatted field.
// ----------------------------------------------------------------------------
module fia_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fia_pkg::fia_stat_type stat,
   output fia_pkg::fia_cmd_type  cmd
);

   fia_pkg::state_type state_ff;
   fia_pkg::state_type state_in;
   logic [1:0]         pos_ff;
   logic [1:0]         pos_in;
   logic               body_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fia_pkg::ST_IDLE;
         pos_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      cmd       = '0;
      req_ready = 1'b0;
      body_last = stat.body_one && ((stat.ord != fia_pkg::ORD_LEFT) || stat.pad_zero);
      unique case (state_ff)
         fia_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = fia_pkg::ST_ROUTE;
            end
         end
         fia_pkg::ST_ROUTE: begin
            priority if (stat.is_dec) begin
               state_in = fia_pkg::ST_CONV;
            end else if (stat.is_num) begin
               state_in = fia_pkg::ST_DIGIT;
            end else begin
               state_in = fia_pkg::ST_PLAN;
            end
         end
         fia_pkg::ST_CONV: begin
            cmd.conv_step = 1'b1;
            if (stat.conv_last) begin
               state_in = fia_pkg::ST_DIGIT;
            end
         end
         fia_pkg::ST_DIGIT: begin
            cmd.digit_step = 1'b1;
            if (stat.digit_last) begin
               state_in = fia_pkg::ST_PLAN;
            end
         end
         fia_pkg::ST_PLAN: begin
            cmd.plan = 1'b1;
            pos_in   = 2'd0;
            state_in = fia_pkg::ST_EMIT;
         end
         fia_pkg::ST_EMIT: begin
            unique case (fia_pkg::seg_of(stat.ord, pos_ff))
               fia_pkg::SEG_SIGN: begin
                  // skip an empty sign segment
                  if (!stat.neg) begin
                     pos_in = pos_ff + 2'd1;
                  end else if (stat.slot_free) begin
                     cmd.emit_sign = 1'b1;
                     pos_in        = pos_ff + 2'd1;
                  end
               end
               fia_pkg::SEG_PAD: begin
                  if (stat.pad_zero) begin
                     pos_in = pos_ff + 2'd1;
                  end else if (stat.slot_free) begin
                     cmd.emit_pad = 1'b1;
                     cmd.last     = (stat.ord == fia_pkg::ORD_LEFT) && stat.pad_one;
                     if (stat.pad_one) begin
                        if (cmd.last) begin
                           state_in = fia_pkg::ST_IDLE;
                        end else begin
                           pos_in = pos_ff + 2'd1;
                        end
                     end
                  end
               end
               default: begin
                  state_in = fia_pkg::ST_FETCH;
               end
            endcase
         end
         fia_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = fia_pkg::ST_BODY;
         end
         fia_pkg::ST_BODY: begin
            if (stat.slot_free) begin
               cmd.emit_body = 1'b1;
               cmd.last      = body_last;
               priority if (body_last) begin
                  state_in = fia_pkg::ST_IDLE;
               end else if (stat.body_one) begin
                  pos_in   = pos_ff + 2'd1;
                  state_in = fia_pkg::ST_EMIT;
               end else begin
                  state_in = fia_pkg::ST_FETCH;
               end
            end
         end
         default: begin
            state_in = fia_pkg::ST_IDLE;
         end
      endcase
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a conversion is in flight");

endmodule
